/* sv/smc_pkg.sv */
// Shared types and constants for the sliding-mode speed controller.
`default_nettype none

package smc_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_SLOPE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCHING_GAIN = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REACHING_RATE  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERALL_GAIN   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_PERIOD = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_MAX   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_MIN   = 4'd7;

    localparam logic [30:0] RST_SURFACE_SLOPE  = 31'd65536;
    localparam logic [30:0] RST_SWITCHING_GAIN = 31'd0;
    localparam logic [30:0] RST_REACHING_RATE  = 31'd0;
    localparam logic [30:0] RST_OVERALL_GAIN   = 31'd65536;
    localparam logic [30:0] RST_INVERSE_PERIOD = 31'd65536;
    localparam logic [31:0] RST_HALF_PERIOD    = 32'd0;
    localparam logic signed [31:0] RST_INTEGRAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] RST_INTEGRAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] reference;
        logic signed [31:0] feedback;
    } t_smc_in;

    typedef struct packed {
        logic signed [31:0] drive_output;
        logic               integral_frozen;
    } t_smc_out;

    typedef struct packed {
        logic start;
        logic shift32;
    } t_smc_mul_ctl;

endpackage

`default_nettype wire

/* sv/smc_mul.sv */
// Shared sign-magnitude multiply unit with round-to-nearest shift and saturation.
`default_nettype none

module smc_mul #(
    parameter int DW = 32,
    parameter int MW = 33
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire smc_pkg::t_smc_mul_ctl  i_ctl,
    input  wire logic signed [MW-1:0]   i_x,
    input  wire logic        [31:0]     i_b,
    output logic                        o_done,
    output logic signed [DW-1:0]        o_sat,
    output logic signed [MW:0]          o_full
);

    localparam int AW = MW + 32;
    localparam int QW = MW + 16;
    localparam logic [QW-1:0] LIM_NEG = QW'(1) << (DW - 1);
    localparam logic [QW-1:0] LIM_POS = LIM_NEG - QW'(1);

    logic [3:0]    r_pipe;
    logic          r_neg;
    logic          r_sh32;
    logic [MW-1:0] r_mag;
    logic [31:0]   r_b;
    logic [63:0]   r_prod;
    logic [AW-1:0] r_acc;

    logic [QW-1:0] q16;
    logic [MW-1:0] q32;
    logic [QW-1:0] qlim;
    logic [QW-1:0] qclip;
    logic [AW-1:0] half;

    always_comb begin
        q16   = r_acc[AW-1:16];
        q32   = r_acc[AW-1:32];
        qlim  = r_neg ? LIM_NEG : LIM_POS;
        qclip = (q16 > qlim) ? qlim : q16;
        half  = r_sh32 ? (AW'(1) << 31) : (AW'(1) << 15);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe <= '0;
        end else begin
            r_pipe <= {r_pipe[2:0], i_ctl.start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_neg  <= i_x[MW-1];
            r_mag  <= i_x[MW-1] ? MW'(-i_x) : MW'(i_x);
            r_b    <= i_b;
            r_sh32 <= i_ctl.shift32;
        end
        if (r_pipe[0]) begin
            r_prod <= 64'(r_mag[31:0]) * 64'(r_b);
        end
        if (r_pipe[1]) begin
            r_acc  <= AW'(r_prod) + half;
            r_prod <= 64'(32'(r_mag[MW-1:32])) * 64'(r_b);
        end
        if (r_pipe[2]) begin
            r_acc <= r_acc + {r_prod[MW-1:0], 32'd0};
        end
        if (r_pipe[3]) begin
            o_sat  <= r_neg ? DW'(-qclip) : DW'(qclip);
            o_full <= r_neg ? -$signed({1'b0, q32}) : $signed({1'b0, q32});
        end
    end

    assign o_done = r_pipe[3];

endmodule

`default_nettype wire

/* sv/sliding_mode_speed_controller_core.sv */
// Sliding-mode speed controller top level: config, sequencer and integrator.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-----------------------
//   input   | in        | i_in_valid / o_in_stall    | i_in  (reference, feedback)
//   output  | out       | o_out_valid / i_out_stall  | o_out (drive_output, frozen)
//   config  | in        | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// Each word runs six multiplies, one after another, on the shared multiply unit
// before the result is published with o_out_valid.
// The next word is accepted in the cycle after the result lands in the output register.
// Reset is synchronous, active low; it restores the register defaults and clears state.
// A stalled output holds; the sequencer waits only if the output register is still full and stalled.
`default_nettype none

module sliding_mode_speed_controller_core #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire smc_pkg::t_smc_in                  i_in,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output smc_pkg::t_smc_out                      o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [smc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [smc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int DW = DATA_WIDTH;
    localparam int MW = (DW + 1 > 33) ? DW + 1 : 33;
    localparam int SW = MW + 2;
    localparam int VW = MW + 2;
    localparam logic [SW-1:0] ONE_SH = SW'(1) << (DW - 1);
    localparam logic signed [SW-1:0] SMAX = $signed(ONE_SH - SW'(1));
    localparam logic signed [SW-1:0] SMIN = $signed(~ONE_SH + SW'(1));

    localparam logic [2:0] OP_DE   = 3'd0;
    localparam logic [2:0] OP_ES   = 3'd1;
    localparam logic [2:0] OP_SQ   = 3'd2;
    localparam logic [2:0] OP_DEC  = 3'd3;
    localparam logic [2:0] OP_GAIN = 3'd4;
    localparam logic [2:0] OP_STEP = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_WAIT = 5'b00100,
        S_POST = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    function automatic logic signed [DW-1:0] sat_dw(input logic signed [SW-1:0] v);
        logic signed [DW-1:0] r;
        if (v > SMAX) begin
            r = SMAX[DW-1:0];
        end else if (v < SMIN) begin
            r = SMIN[DW-1:0];
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

    t_state r_state, n_state;
    logic [2:0] r_op;

    logic [30:0]        r_slope, r_miu, r_rate, r_gain, r_inv;
    logic [31:0]        r_half;
    logic signed [31:0] r_imax, r_imin;

    logic signed [DW-1:0] r_pe, r_pu;
    logic signed [31:0]   r_iv;
    logic                 r_frz;

    logic signed [DW-1:0] r_e, r_de, r_s, r_t, r_u;

    logic                  r_out_valid;
    smc_pkg::t_smc_out     r_out;

    smc_pkg::t_smc_mul_ctl mul_ctl;
    logic signed [MW-1:0]  mul_x;
    logic [31:0]           mul_b;
    logic                  mul_done;
    logic signed [DW-1:0]  mul_sat;
    logic signed [MW:0]    mul_full;

    logic signed [SW-1:0] sgn_miu;
    logic signed [VW-1:0] v_sum;
    logic signed [VW-1:0] v_max, v_min;
    logic                 opposite, in_band;
    logic                 in_acc;
    logic                 out_free;

    smc_mul #(
        .DW (DW),
        .MW (MW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mul_ctl),
        .i_x     (mul_x),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_sat   (mul_sat),
        .o_full  (mul_full)
    );

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        mul_ctl.start   = (r_state == S_LOAD);
        mul_ctl.shift32 = (r_op == OP_STEP);
        case (r_op)
            OP_DE: begin
                mul_x = MW'(sat_dw(SW'(r_e) - SW'(r_pe)));
                mul_b = {1'b0, r_inv};
            end
            OP_ES: begin
                mul_x = MW'(r_e);
                mul_b = {1'b0, r_slope};
            end
            OP_SQ: begin
                mul_x = MW'(r_s);
                mul_b = {1'b0, r_rate};
            end
            OP_DEC: begin
                mul_x = MW'(r_de);
                mul_b = {1'b0, r_slope};
            end
            OP_GAIN: begin
                mul_x = MW'(r_t);
                mul_b = {1'b0, r_gain};
            end
            OP_STEP: begin
                mul_x = MW'(r_u) + MW'(r_pu);
                mul_b = r_half;
            end
            default: begin
                mul_x = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        if (r_s > 0) begin
            sgn_miu = SW'($signed({1'b0, r_miu}));
        end else if (r_s < 0) begin
            sgn_miu = -SW'($signed({1'b0, r_miu}));
        end else begin
            sgn_miu = '0;
        end
        v_sum    = VW'(r_iv) + VW'(mul_full);
        v_max    = VW'(r_imax);
        v_min    = VW'(r_imin);
        opposite = (r_u < 0 && r_iv > 0) || (r_u > 0 && r_iv < 0);
        in_band  = (r_iv < r_imax) && (r_iv > r_imin);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (mul_done) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                n_state = (r_op == OP_STEP) ? S_DONE : S_LOAD;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_DE;
            r_out_valid <= 1'b0;
            r_slope     <= smc_pkg::RST_SURFACE_SLOPE;
            r_miu       <= smc_pkg::RST_SWITCHING_GAIN;
            r_rate      <= smc_pkg::RST_REACHING_RATE;
            r_gain      <= smc_pkg::RST_OVERALL_GAIN;
            r_inv       <= smc_pkg::RST_INVERSE_PERIOD;
            r_half      <= smc_pkg::RST_HALF_PERIOD;
            r_imax      <= smc_pkg::RST_INTEGRAL_MAX;
            r_imin      <= smc_pkg::RST_INTEGRAL_MIN;
            r_pe        <= '0;
            r_pu        <= '0;
            r_iv        <= '0;
            r_frz       <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    smc_pkg::CFG_SURFACE_SLOPE:  r_slope <= i_cfg_data[30:0];
                    smc_pkg::CFG_SWITCHING_GAIN: r_miu   <= i_cfg_data[30:0];
                    smc_pkg::CFG_REACHING_RATE:  r_rate  <= i_cfg_data[30:0];
                    smc_pkg::CFG_OVERALL_GAIN:   r_gain  <= i_cfg_data[30:0];
                    smc_pkg::CFG_INVERSE_PERIOD: r_inv   <= i_cfg_data[30:0];
                    smc_pkg::CFG_HALF_PERIOD:    r_half  <= i_cfg_data;
                    smc_pkg::CFG_INTEGRAL_MAX:   r_imax  <= $signed(i_cfg_data);
                    smc_pkg::CFG_INTEGRAL_MIN:   r_imin  <= $signed(i_cfg_data);
                    default: ;
                endcase
            end

            if (in_acc) begin
                r_op <= OP_DE;
            end

            if (r_state == S_POST) begin
                if (r_op == OP_STEP) begin
                    if (r_frz) begin
                        if (opposite || in_band) begin
                            r_frz <= 1'b0;
                        end
                    end else if (v_sum > v_max) begin
                        r_iv  <= r_imax;
                        r_frz <= 1'b1;
                    end else if (v_sum < v_min) begin
                        r_iv  <= r_imin;
                        r_frz <= 1'b1;
                    end else begin
                        r_iv <= v_sum[31:0];
                    end
                    r_pe <= r_e;
                    r_pu <= r_u;
                end else begin
                    r_op <= r_op + 3'd1;
                end
            end

            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_e <= sat_dw(SW'(i_in.reference) - SW'(i_in.feedback));
        end
        if (r_state == S_POST) begin
            case (r_op)
                OP_DE:   r_de <= mul_sat;
                OP_ES:   r_s  <= sat_dw(SW'(mul_sat) + SW'(r_de));
                OP_SQ:   r_t  <= sat_dw(SW'(sat_dw(sgn_miu)) + SW'(mul_sat));
                OP_DEC:  r_t  <= sat_dw(SW'(r_t) + SW'(mul_sat));
                OP_GAIN: r_u  <= mul_sat;
                default: ;
            endcase
        end
        if (r_state == S_DONE && out_free) begin
            r_out.drive_output    <= r_iv;
            r_out.integral_frozen <= r_frz;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire
